// ===== hw/rtl/search_query_tokenizer_macros.svh =====
// assertion macros for the search query tokenizer
`ifndef SEARCH_QUERY_TOKENIZER_MACROS_SVH
`define SEARCH_QUERY_TOKENIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SQT_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SQT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/sqt_pkg.sv =====
// shared types, codes and character classes for the search query tokenizer
`timescale 1ns / 1ps

package sqt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_UNDERS = 3'd1,
        MODE_IDENT  = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_STRING = 3'd4
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_OPERATOR = 3'd0,
        KIND_IDENT    = 3'd1,
        KIND_NUMBER   = 3'd2,
        KIND_STRING   = 3'd3,
        KIND_END      = 3'd4
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  op;
        logic        ovf;
    } sqt_result_t;

    typedef struct packed {
        logic        valid;
        sqt_result_t res;
    } sqt_slot_t;

    // results one transaction can cause, in delivery order
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_APOS       = 8'h27;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_QMARK      = 8'h3F;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == CH_COLON || c == CH_SLASH || c == CH_DOT || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_STAR || c == CH_QMARK;
    endfunction

endpackage

// ===== hw/rtl/search_query_tokenizer.sv =====
// top level of the search query tokenizer: input register, scan chain and state
`timescale 1ns / 1ps
`include "search_query_tokenizer_macros.svh"

// Streaming tokenizer for search query text. Bytes of a buffer arrive one per input
// transaction, the last one flagged by end_of_buffer; out come tokens as kind, start
// offset and length (operators : / . ( ) * ?, identifiers, numbers, double-quoted
// strings), followed by an end marker whose start is the buffer length. One byte is
// held back as lookahead, so the token a byte closes usually appears one transaction
// late. Unterminated strings and underscore runs not followed by a letter or digit
// are dropped. Positions saturate at 2^POSITION_BITS - 1 and raise position_overflow;
// the 16-bit start and length fields carry the low bits. Each transaction goes
// through an input register and then, after combinational scanning, into the
// result buffer, whose registers drive the output. Input is taken every cycle as
// long as the result buffer can drain: results leave one per cycle while out_ready
// is high, so a byte that causes several results holds the output until all have
// gone (at most two for an ordinary byte, up to four for the final byte of a
// buffer). After the end marker the
// block is back at its reset state and the next byte starts a new buffer at offset 0.

module search_query_tokenizer import sqt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic [7:0]  operator_char,
    output logic        position_overflow,
    output logic        last_result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // input register
    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic                     process_fire;
    logic                     buffer_free;

    // scanner state
    scan_mode_t               scan_mode_reg;
    scan_mode_t               scan_mode_next;
    logic [POSITION_BITS-1:0] start_offset_reg;
    logic [POSITION_BITS-1:0] start_offset_next;
    logic [POSITION_BITS-1:0] byte_position_reg;
    logic [POSITION_BITS-1:0] byte_position_next;
    logic [7:0]               held_byte_reg;
    logic [7:0]               held_byte_next;
    logic                     held_valid_reg;
    logic                     held_valid_next;
    logic                     overflow_seen_reg;
    logic                     overflow_seen_next;

    // held byte scan
    scan_mode_t               held_mode;
    logic [POSITION_BITS-1:0] held_start;
    sqt_slot_t                held_close;
    sqt_slot_t                held_op;
    scan_mode_t               mode1;
    logic [POSITION_BITS-1:0] start1;
    logic [POSITION_BITS-1:0] pos1;
    logic                     ovf1;

    // final byte scan
    scan_mode_t               mode2;
    logic [POSITION_BITS-1:0] start2;
    sqt_slot_t                last_close;
    sqt_slot_t                last_op;
    logic [POSITION_BITS-1:0] pos2;
    logic                     ovf2;

    // virtual zero byte and end marker
    logic [POSITION_BITS-1:0] zero_len;
    logic [31:0]              zero_len_wide;
    logic [31:0]              zero_start_wide;
    logic [31:0]              end_pos_wide;
    sqt_slot_t                zero_close;
    sqt_slot_t                end_slot;
    sqt_slot_t                slots [NUM_SLOTS];
    sqt_result_t              out_res;

    // take a new transaction while the held one moves into the result buffer
    assign process_fire = in_valid_reg && buffer_free;
    assign in_ready     = !in_valid_reg || process_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (process_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= end_of_buffer;
        end
    end

    // held byte, with the incoming byte as lookahead
    sqt_scan_unit #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan_held (
        .mode         (scan_mode_reg),
        .start_offset (start_offset_reg),
        .cur_byte     (held_byte_reg),
        .look_byte    (in_byte_reg),
        .pos          (byte_position_reg),
        .ovf          (overflow_seen_reg),
        .mode_out     (held_mode),
        .start_out    (held_start),
        .close_slot   (held_close),
        .op_slot      (held_op)
    );

    // step past the held byte, saturating at the top of the range
    always_comb
    begin
        mode1  = scan_mode_reg;
        start1 = start_offset_reg;
        pos1   = byte_position_reg;
        ovf1   = overflow_seen_reg;
        if (held_valid_reg)
        begin
            mode1  = held_mode;
            start1 = held_start;
            if (byte_position_reg == POS_MAX)
                ovf1 = 1'b1;
            else
                pos1 = byte_position_reg + POSITION_BITS'(1);
        end
    end

    // final byte of a buffer has a zero lookahead
    sqt_scan_unit #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan_last (
        .mode         (mode1),
        .start_offset (start1),
        .cur_byte     (in_byte_reg),
        .look_byte    (8'd0),
        .pos          (pos1),
        .ovf          (ovf1),
        .mode_out     (mode2),
        .start_out    (start2),
        .close_slot   (last_close),
        .op_slot      (last_op)
    );

    assign pos2 = (pos1 == POS_MAX) ? POS_MAX : pos1 + POSITION_BITS'(1);
    assign ovf2 = ovf1 || (pos1 == POS_MAX);

    // a zero byte closes an open identifier or number and nothing else
    assign zero_len        = pos2 - start2;
    assign zero_len_wide   = 32'(zero_len);
    assign zero_start_wide = 32'(start2);
    assign end_pos_wide    = 32'(pos2);

    always_comb
    begin
        zero_close.valid      = mode2 == MODE_IDENT || mode2 == MODE_NUMBER;
        zero_close.res.kind   = (mode2 == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        zero_close.res.start  = zero_start_wide[15:0];
        zero_close.res.length = zero_len_wide[15:0];
        zero_close.res.op     = 8'd0;
        zero_close.res.ovf    = ovf2;

        end_slot.valid        = 1'b1;
        end_slot.res.kind     = KIND_END;
        end_slot.res.start    = end_pos_wide[15:0];
        end_slot.res.length   = 16'd0;
        end_slot.res.op       = 8'd0;
        end_slot.res.ovf      = ovf2;
    end

    // results in delivery order; the final byte adds its own and the end marker
    always_comb
    begin
        slots[0]       = held_close;
        slots[1]       = held_op;
        slots[2]       = last_close;
        slots[3]       = last_op;
        slots[4]       = zero_close;
        slots[5]       = end_slot;
        slots[0].valid = held_close.valid && held_valid_reg;
        slots[1].valid = held_op.valid && held_valid_reg;
        slots[2].valid = last_close.valid && in_last_reg;
        slots[3].valid = last_op.valid && in_last_reg;
        slots[4].valid = zero_close.valid && in_last_reg;
        slots[5].valid = in_last_reg;
    end

    // after the end marker everything returns to reset for the next buffer
    always_comb
    begin
        scan_mode_next     = scan_mode_reg;
        start_offset_next  = start_offset_reg;
        byte_position_next = byte_position_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        overflow_seen_next = overflow_seen_reg;
        if (process_fire)
        begin
            if (in_last_reg)
            begin
                scan_mode_next     = MODE_IDLE;
                start_offset_next  = '0;
                byte_position_next = '0;
                held_byte_next     = 8'd0;
                held_valid_next    = 1'b0;
                overflow_seen_next = 1'b0;
            end
            else
            begin
                scan_mode_next     = mode1;
                start_offset_next  = start1;
                byte_position_next = pos1;
                held_byte_next     = in_byte_reg;
                held_valid_next    = 1'b1;
                overflow_seen_next = ovf1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg     <= MODE_IDLE;
            start_offset_reg  <= '0;
            byte_position_reg <= '0;
            held_byte_reg     <= 8'd0;
            held_valid_reg    <= 1'b0;
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            scan_mode_reg     <= scan_mode_next;
            start_offset_reg  <= start_offset_next;
            byte_position_reg <= byte_position_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

    sqt_result_buffer u_result_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (process_fire),
        .slots_in  (slots),
        .free      (buffer_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (out_res),
        .last      (last_result)
    );

    assign token_kind        = out_res.kind;
    assign token_start       = out_res.start;
    assign token_length      = out_res.length;
    assign operator_char     = out_res.op;
    assign position_overflow = out_res.ovf;

    // the end marker closes the results of its transaction
    `SQT_ASSERT_IMPL(a_end_is_last, out_valid && token_kind == KIND_END,
        last_result, "end marker not last")
    // only operator tokens carry a character, always one byte long
    `SQT_ASSERT_IMPL(a_op_fields, out_valid && token_kind != KIND_OPERATOR,
        operator_char == 8'd0, "operator char on non-operator")
    `SQT_ASSERT_IMPL(a_op_length, out_valid && token_kind == KIND_OPERATOR,
        token_length == 16'd1, "operator length not one")
    // a finished buffer leaves no held byte and restarts at offset zero
    `SQT_ASSERT_NEXT(a_buffer_restart, process_fire && in_last_reg,
        !held_valid_reg && byte_position_reg == '0 && scan_mode_reg == MODE_IDLE,
        "state not cleared after end")

endmodule

// ===== hw/rtl/sqt_scan_unit.sv =====
// scans one byte with its lookahead: next mode, token close and operator emit
`timescale 1ns / 1ps

module sqt_scan_unit import sqt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  scan_mode_t               mode,
    input  logic [POSITION_BITS-1:0] start_offset,
    input  logic [7:0]               cur_byte,
    input  logic [7:0]               look_byte,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic                     ovf,
    output scan_mode_t               mode_out,
    output logic [POSITION_BITS-1:0] start_out,
    output sqt_slot_t                close_slot,
    output sqt_slot_t                op_slot
);

    logic                     alpha;
    logic                     digit;
    logic                     joint;
    logic                     rescan;
    logic                     close_valid;
    logic                     close_string;
    logic                     op_valid;
    token_kind_t              close_kind;
    logic [POSITION_BITS-1:0] plain_len;
    logic [POSITION_BITS:0]   string_sum;
    logic [POSITION_BITS-1:0] string_len;
    logic [31:0]              len_wide;
    logic [31:0]              start_wide;
    logic [31:0]              pos_wide;

    always_comb
    begin
        alpha = is_alpha(cur_byte);
        digit = is_digit(cur_byte);
        // apostrophe before a letter, hyphen before a letter or digit
        joint = (cur_byte == CH_APOS && is_alpha(look_byte)) ||
                (cur_byte == CH_HYPHEN && (is_alpha(look_byte) || is_digit(look_byte)));
        mode_out     = mode;
        start_out    = start_offset;
        close_valid  = 1'b0;
        close_string = 1'b0;
        close_kind   = KIND_IDENT;
        rescan       = 1'b0;
        case (mode)
            MODE_UNDERS:
            begin
                if (alpha || digit)
                    mode_out = MODE_IDENT;
                else if (cur_byte != CH_UNDERSCORE)
                    mode_out = MODE_IDLE;
            end
            MODE_IDENT:
            begin
                if (cur_byte != CH_UNDERSCORE && !alpha && !digit && !joint)
                begin
                    close_valid = 1'b1;
                    close_kind  = KIND_IDENT;
                    rescan      = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!alpha && !digit)
                begin
                    close_valid = 1'b1;
                    close_kind  = KIND_NUMBER;
                    rescan      = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (cur_byte == CH_QUOTE)
                begin
                    close_valid  = 1'b1;
                    close_kind   = KIND_STRING;
                    close_string = 1'b1;
                    mode_out     = MODE_IDLE;
                end
            end
            default:
            begin
                rescan = 1'b1;
            end
        endcase

        // idle scan, also for the byte that ended an identifier or number
        op_valid = 1'b0;
        if (rescan)
        begin
            mode_out = MODE_IDLE;
            if (is_op(cur_byte))
                op_valid = 1'b1;
            else if (cur_byte == CH_UNDERSCORE || alpha)
            begin
                start_out = pos;
                mode_out  = alpha ? MODE_IDENT : MODE_UNDERS;
            end
            else if (digit)
            begin
                start_out = pos;
                mode_out  = MODE_NUMBER;
            end
            else if (cur_byte == CH_QUOTE)
            begin
                start_out = pos;
                mode_out  = MODE_STRING;
            end
        end
    end

    // string length counts the closing quote and may need to saturate
    assign plain_len  = pos - start_offset;
    assign string_sum = {1'b0, pos} + {{POSITION_BITS{1'b0}}, 1'b1}
                        - {1'b0, start_offset};
    assign string_len = string_sum[POSITION_BITS] ? {POSITION_BITS{1'b1}}
                                                  : string_sum[POSITION_BITS-1:0];
    assign len_wide   = close_string ? 32'(string_len) : 32'(plain_len);
    assign start_wide = 32'(start_offset);
    assign pos_wide   = 32'(pos);

    always_comb
    begin
        close_slot.valid      = close_valid;
        close_slot.res.kind   = close_kind;
        close_slot.res.start  = start_wide[15:0];
        close_slot.res.length = len_wide[15:0];
        close_slot.res.op     = 8'd0;
        close_slot.res.ovf    = ovf;

        op_slot.valid         = op_valid;
        op_slot.res.kind      = KIND_OPERATOR;
        op_slot.res.start     = pos_wide[15:0];
        op_slot.res.length    = 16'd1;
        op_slot.res.op        = cur_byte;
        op_slot.res.ovf       = ovf;
    end

endmodule

// ===== hw/rtl/sqt_result_buffer.sv =====
// result buffer: holds the results of one transaction and drains one per cycle while out_ready is high
`timescale 1ns / 1ps

module sqt_result_buffer import sqt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  sqt_slot_t   slots_in [NUM_SLOTS],
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output sqt_result_t result,
    output logic        last
);

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;
    sqt_result_t          res_reg [NUM_SLOTS];
    logic [SLOT_BITS-1:0] sel;
    logic [NUM_SLOTS-1:0] sel_mask;
    logic [NUM_SLOTS-1:0] remaining;

    // lowest valid slot goes first
    always_comb
    begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i])
                sel = SLOT_BITS'(i);
        end
    end

    assign sel_mask  = NUM_SLOTS'(1) << sel;
    assign out_valid = |valid_reg;
    assign result    = res_reg[sel];
    assign last      = (valid_reg & ~sel_mask) == '0;
    assign remaining = (out_valid && out_ready) ? (valid_reg & ~sel_mask) : valid_reg;
    assign free      = remaining == '0;

    always_comb
    begin
        valid_next = remaining;
        if (load)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                valid_next[i] = slots_in[i].valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                res_reg[i] <= slots_in[i].res;
        end
    end

endmodule

// ===== dv/search_query_tokenizer_check.sv =====
// token predictor and result checker for the search query tokenizer testbench
`timescale 1ns / 1ps

module search_query_tokenizer_check import sqt_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  token_kind,
    input  logic [15:0] token_start,
    input  logic [15:0] token_length,
    input  logic [7:0]  operator_char,
    input  logic        position_overflow,
    input  logic        last_result,
    output int          fail_count,
    output int          pending
);

    localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 1;

    typedef struct packed {
        sqt_result_t res;
        logic        last;
    } token_exp_t;

    // lexer state as the block should hold it
    scan_mode_t       mode;
    longint unsigned  tok_start;
    longint unsigned  cur_pos;
    logic [7:0]       held;
    bit               held_ok;
    bit               ovf;

    token_exp_t step_tokens[$];
    token_exp_t expected_tokens[$];
    int         mismatches = 0;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic bit is_numeral(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_operator(logic [7:0] c);
        return c == CH_COLON || c == CH_SLASH || c == CH_DOT || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_STAR || c == CH_QMARK;
    endfunction

    function automatic void clear_scan();
        mode      = MODE_IDLE;
        tok_start = 0;
        cur_pos   = 0;
        held      = 8'h00;
        held_ok   = 1'b0;
        ovf       = 1'b0;
    endfunction

    function automatic void push_token(token_kind_t kind, longint unsigned start,
                                       longint unsigned len, logic [7:0] op);
        token_exp_t t;
        if (step_tokens.size() >= NUM_SLOTS)
            return;
        if (len > POS_MAX)
            len = POS_MAX;
        t.res.kind   = kind;
        t.res.start  = start[15:0];
        t.res.length = len[15:0];
        t.res.op     = op;
        t.res.ovf    = ovf;
        t.last       = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void step_pos();
        if (cur_pos >= POS_MAX) begin
            cur_pos = POS_MAX;
            ovf     = 1'b1;
        end
        else begin
            cur_pos++;
        end
    endfunction

    // scan byte c at offset pos with la as lookahead; a closing byte is rescanned from idle
    function automatic void scan_byte(logic [7:0] c, logic [7:0] la, longint unsigned pos);
        bit again;
        bit letter;
        bit numeral;
        bit joint;
        again = 1'b1;
        while (again) begin
            letter  = is_letter(c);
            numeral = is_numeral(c);
            again   = 1'b0;
            case (mode)
                MODE_UNDERS:
                begin
                    if (letter || numeral)
                        mode = MODE_IDENT;
                    else if (c != CH_UNDERSCORE)
                        mode = MODE_IDLE;
                end
                MODE_IDENT:
                begin
                    joint = (c == CH_APOS && is_letter(la)) ||
                            (c == CH_HYPHEN && (is_letter(la) || is_numeral(la)));
                    if (c != CH_UNDERSCORE && !letter && !numeral && !joint) begin
                        push_token(KIND_IDENT, tok_start, pos - tok_start, 8'h00);
                        mode  = MODE_IDLE;
                        again = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (!letter && !numeral) begin
                        push_token(KIND_NUMBER, tok_start, pos - tok_start, 8'h00);
                        mode  = MODE_IDLE;
                        again = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE) begin
                        push_token(KIND_STRING, tok_start, pos + 1 - tok_start, 8'h00);
                        mode = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode = MODE_IDLE;
                    if (is_operator(c)) begin
                        push_token(KIND_OPERATOR, pos, 1, c);
                    end
                    else if (c == CH_UNDERSCORE || letter) begin
                        tok_start = pos;
                        mode      = letter ? MODE_IDENT : MODE_UNDERS;
                    end
                    else if (numeral) begin
                        tok_start = pos;
                        mode      = MODE_NUMBER;
                    end
                    else if (c == CH_QUOTE) begin
                        tok_start = pos;
                        mode      = MODE_STRING;
                    end
                end
            endcase
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : watch
        token_exp_t want;
        if (!rst_n) begin
            clear_scan();
            expected_tokens.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with none expected: kind %0d start %0d length %0d",
                           token_kind, token_start, token_length);
                    mismatches++;
                end
                else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.res.kind, token_kind);
                    check_field("token_start", want.res.start, token_start);
                    check_field("token_length", want.res.length, token_length);
                    check_field("operator_char", want.res.op, operator_char);
                    check_field("position_overflow", want.res.ovf, position_overflow);
                    check_field("last_result", want.last, last_result);
                end
            end
            if (in_valid && in_ready) begin
                step_tokens.delete();
                if (held_ok) begin
                    scan_byte(held, data_byte, cur_pos);
                    step_pos();
                end
                if (end_of_buffer) begin
                    // final byte sees a zero lookahead, then a zero byte closes open words
                    scan_byte(data_byte, 8'h00, cur_pos);
                    step_pos();
                    scan_byte(8'h00, 8'h00, cur_pos);
                    push_token(KIND_END, cur_pos, 0, 8'h00);
                    clear_scan();
                end
                else begin
                    held    = data_byte;
                    held_ok = 1'b1;
                end
                if (step_tokens.size() > 0)
                    step_tokens[step_tokens.size() - 1].last = 1'b1;
                foreach (step_tokens[i])
                    expected_tokens.push_back(step_tokens[i]);
            end
        end
        fail_count <= mismatches;
        pending    <= expected_tokens.size();
    end

endmodule

// ===== dv/search_query_tokenizer_tb.sv =====
// top of the search query tokenizer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module search_query_tokenizer_tb import sqt_pkg::*;;

    // cycles with no transaction on either channel before the run is declared hung;
    // real gaps are idle bursts on either side plus at most four results per byte
    localparam int STALL_LIMIT = 2000;

    // random part: about this many bytes, the tail of it without any idling
    localparam int RANDOM_BYTES = 340;
    localparam int CALM_FROM    = 290;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_buffer = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  operator_char;
    logic        position_overflow;
    logic        last_result;

    int fail_count;
    int pending;

    // set for the last part of the run: no idling on either side
    bit calm = 1'b0;

    search_query_tokenizer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .end_of_buffer    (end_of_buffer),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .token_kind       (token_kind),
        .token_start      (token_start),
        .token_length     (token_length),
        .operator_char    (operator_char),
        .position_overflow(position_overflow),
        .last_result      (last_result)
    );

    // predicts every token and compares what comes out of the block
    search_query_tokenizer_check i_token_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .end_of_buffer    (end_of_buffer),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .token_kind       (token_kind),
        .token_start      (token_start),
        .token_length     (token_length),
        .operator_char    (operator_char),
        .position_overflow(position_overflow),
        .last_result      (last_result),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one byte transaction; sometimes preceded by an idle burst on the input side
    task automatic send_byte(logic [7:0] b, bit eob);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_buffer <= eob;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // text bytes in order; closes marks the last byte as the end of the buffer
    task automatic send_text(string s, bit closes);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], closes && i == s.len() - 1);
    endtask

    // hold the input off until every predicted token has come out
    task automatic drain_tokens();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        int v;
        v = $urandom_range(0, 51);
        return v < 26 ? 8'(8'h61 + v) : 8'(8'h41 + v - 26);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 6))
            0: return CH_COLON;
            1: return CH_SLASH;
            2: return CH_DOT;
            3: return CH_LPAREN;
            4: return CH_RPAREN;
            5: return CH_STAR;
            default: return CH_QMARK;
        endcase
    endfunction

    // output side: ready drops in bursts, with high stretches between
    initial
    begin : sink
        int n;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 9);
            end
            else
            begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 20);
            end
            repeat (n) @(posedge clk);
        end
    end

    // hang detection: counts cycles in which neither channel moves a transaction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] query[$];
        int         rand_bytes;
        rand_bytes = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // every operator, the last one closing the buffer
        send_text(":/.()*?", 1'b1);
        // underscore run into a word, apostrophe and hyphen joints,
        // apostrophe with the zero lookahead of the final byte
        send_text("_x'y-z-9'", 1'b1);
        // underscore run swallowing an operator, number ended by a quote, closed string
        send_text("_:7a\"q\"", 1'b1);
        // word closed by a zero byte, a skipped high byte, unterminated string at the end
        send_text("k", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        // single byte buffer: number closed by the end of the buffer
        send_text("9", 1'b1);

        drain_tokens();

        // random queries, mostly well-formed words with some noise mixed in
        while (rand_bytes < RANDOM_BYTES)
        begin
            query.delete();
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 9))
                    0: query.push_back(pick_op());
                    1, 2:
                    begin
                        repeat ($urandom_range(0, 2)) query.push_back(CH_UNDERSCORE);
                        query.push_back(pick_letter());
                        repeat ($urandom_range(0, 5))
                        begin
                            case ($urandom_range(0, 5))
                                0: query.push_back(CH_UNDERSCORE);
                                1: query.push_back(pick_digit());
                                2:
                                begin
                                    query.push_back(CH_APOS);
                                    query.push_back(pick_letter());
                                end
                                3:
                                begin
                                    query.push_back(CH_HYPHEN);
                                    query.push_back($urandom_range(0, 1) ? pick_letter()
                                                                          : pick_digit());
                                end
                                4:
                                begin
                                    // joint character with whatever follows
                                    query.push_back($urandom_range(0, 1) ? CH_APOS
                                                                          : CH_HYPHEN);
                                    query.push_back(8'($urandom_range(0, 255)));
                                end
                                default: query.push_back(pick_letter());
                            endcase
                        end
                    end
                    3:
                    begin
                        repeat ($urandom_range(1, 4)) query.push_back(pick_digit());
                        if ($urandom_range(0, 3) == 0)
                            query.push_back(pick_letter());
                    end
                    4:
                    begin
                        query.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 4))
                            query.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        if ($urandom_range(0, 7) != 0)
                            query.push_back(CH_QUOTE);
                    end
                    5:
                    begin
                        // dropped underscore run
                        repeat ($urandom_range(1, 3)) query.push_back(CH_UNDERSCORE);
                        query.push_back($urandom_range(0, 1) ? pick_op() : 8'h20);
                    end
                    6, 7: query.push_back(8'h20);
                    default: query.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            foreach (query[i])
                send_byte(query[i], i == query.size() - 1);
            rand_bytes += query.size();
            if (rand_bytes >= CALM_FROM && !calm)
                calm <= 1'b1;
            else if (!calm && $urandom_range(0, 9) == 0)
                drain_tokens();
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
